@@ rtl/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types, widths and constants of the beat-locked column stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

   // Channel payload widths
   localparam int PHASE_W    = 16;
   localparam int COL_W      = 4;
   localparam int ROW_W      = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_COLUMN_COUNT       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOOP_QUARTER_BEATS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_JITTER_FRACTION    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SKIP_PROBABILITY   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HASH_SEED          = 3'd5;

   // Datapath widths
   localparam int WORD_W = 32;
   localparam int PROD_W = 64;
   localparam int DVD_W  = 48;   // dividend of the serial divider
   localparam int DVS_W  = 9;    // divisor of the serial divider
   localparam int NUM_W  = 58;   // {bar_count, phase} * 16 * rows
   localparam int REM_W  = 25;   // remainder of num / (q << 16)
   localparam int THR_W  = 26;   // (65536 - offset) * q

   // Offsets, Q0.16
   localparam logic [15:0] JITTER_MAX  = 16'd62259;
   localparam logic [15:0] SKIP_OFFSET = 16'd58982;
   localparam logic [16:0] ONE_Q16     = 17'h10000;
   localparam logic [15:0] HALF_BAR    = 16'd32768;

   // Hash constants
   localparam logic [WORD_W-1:0] GOLDEN  = 32'h9E3779B9;
   localparam logic [WORD_W-1:0] GOLDEN2 = 32'h3C6EF372;   // 2 * GOLDEN mod 2^32
   localparam logic [WORD_W-1:0] MIX_K1  = 32'hED5AD4BB;
   localparam logic [WORD_W-1:0] MIX_K2  = 32'hAC4C1B51;
   localparam logic [WORD_W-1:0] MIX_K3  = 32'h31848BAB;

   // Multiplier operation codes
   localparam logic [1:0] MUL_PLAIN = 2'd0;
   localparam logic [1:0] MUL_MIX17 = 2'd1;
   localparam logic [1:0] MUL_MIX11 = 2'd2;
   localparam logic [1:0] MUL_MIX15 = 2'd3;

   typedef struct packed {
      logic [1:0]        mode;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DVD_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

   // Last xor-shift of the mixer, after the third multiply
   function automatic logic [WORD_W-1:0] mix_tail(input logic [WORD_W-1:0] x);
      return x ^ (x >> 14);
   endfunction

endpackage

@@ rtl/bls_req_if.sv @@
// ----------------------------------------------------------------------------
// bls_req_if
// Input channel: one bar-phase sample per transaction.
// ----------------------------------------------------------------------------
interface bls_req_if
   import bls_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [PHASE_W-1:0] bar_phase;

   modport source (output valid, output bar_phase, input ready);
   modport sink   (input valid, input bar_phase, output ready);
endinterface

@@ rtl/bls_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bls_rsp_if
// Result channel: one lit row per active column.
// ----------------------------------------------------------------------------
interface bls_rsp_if
   import bls_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] column_index;
   logic [ROW_W-1:0] lit_row;
   logic             last_column;

   modport source (output valid, output column_index, output lit_row,
                   output last_column, input ready);
   modport sink   (input valid, input column_index, input lit_row,
                   input last_column, output ready);
endinterface

@@ rtl/bls_csr_if.sv @@
// ----------------------------------------------------------------------------
// bls_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bls_csr_if
   import bls_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/bls_mult.sv @@
// ----------------------------------------------------------------------------
// bls_mult
// Shared 32x32 multiplier with registered product. The mix modes apply the
// hash xor-shift to operand a and multiply by the matching mixer constant.
// ----------------------------------------------------------------------------
module bls_mult
   import bls_pkg::*;
(
   input  logic              clock,
   input  mul_req_type       req,
   output logic [PROD_W-1:0] product_ff
);

   logic [WORD_W-1:0] op_a;
   logic [WORD_W-1:0] op_b;
   logic [PROD_W-1:0] product_in;

   always_comb begin
      unique case (req.mode)
         MUL_PLAIN: begin
            op_a = req.a;
            op_b = req.b;
         end
         MUL_MIX17: begin
            op_a = req.a ^ (req.a >> 17);
            op_b = MIX_K1;
         end
         MUL_MIX11: begin
            op_a = req.a ^ (req.a >> 11);
            op_b = MIX_K2;
         end
         MUL_MIX15: begin
            op_a = req.a ^ (req.a >> 15);
            op_b = MIX_K3;
         end
      endcase
      product_in = {{(PROD_W-WORD_W){1'b0}}, op_a} * {{(PROD_W-WORD_W){1'b0}}, op_b};
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

@@ rtl/bls_divider.sv @@
// ----------------------------------------------------------------------------
// bls_divider
// Restoring divider, one quotient bit per cycle. Once the last quotient bit
// is in, done pulses for one cycle with quotient and remainder valid.
// ----------------------------------------------------------------------------
module bls_divider
   import bls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] count_ff;
   logic [DVD_W-1:0] dvd_ff;
   logic [DVD_W-1:0] dvd_in;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] rem_in;
   logic [DVS_W-1:0] div_ff;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;

   always_comb begin
      trial  = {rem_ff, dvd_ff[DVD_W-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = (trial >= {1'b0, div_ff});
      rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      // dividend shifts out at the top while quotient bits shift in below
      dvd_in = {dvd_ff[DVD_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(DVD_W);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         dvd_ff <= req.dividend;
         rem_ff <= '0;
         div_ff <= req.divisor;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign rsp.busy      = busy_ff;
   assign rsp.done      = done_ff;
   assign rsp.quotient  = dvd_ff;
   assign rsp.remainder = rem_ff;

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   a_finish_flags_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff)
      else $error("divider finished without done");

endmodule

@@ rtl/beat_locked_column_stepper_core.sv @@
// ----------------------------------------------------------------------------
// beat_locked_column_stepper_core
// Turns bar-phase samples into one lit row per active column.
//
// req_port takes one bar_phase sample (Q0.16) per transaction. The block
// counts bar wraps, forms the step clock, hashes every column for its early
// step and returns one transaction per active column on rsp_port, in column
// order, with last_column set on the final one. csr_port writes the six
// configuration registers and is always ready; write only while idle.
// The block takes one sample at a time. Setup forms the operand products and
// thresholds, runs three passes of the serial divider, for the step clock, the
// row index and the skip column, and seven hash mixes on the shared
// multiplier; each active column then takes four mixes and the output load.
// req_port.ready returns once the last result has been loaded into the
// output register.
// Reset restores the register defaults and leaves the clock unseeded: the
// first sample seeds the wrap detector. A stalled receiver holds the output
// register and the sequencer waits before loading the next column.
// ----------------------------------------------------------------------------
module beat_locked_column_stepper_core
   import bls_pkg::*;
#(
   parameter int MAX_COLUMNS = 16,
   parameter int MAX_ROWS    = 32
)
(
   input  logic       clock,
   input  logic       reset,
   bls_req_if.sink    req_port,
   bls_rsp_if.source  rsp_port,
   bls_csr_if.sink    csr_port
);

   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] ST_IDLE    = 4'd0;
   localparam logic [STATE_W-1:0] ST_NUM_HI  = 4'd1;
   localparam logic [STATE_W-1:0] ST_NUM_LO  = 4'd2;
   localparam logic [STATE_W-1:0] ST_NUM_SUM = 4'd3;
   localparam logic [STATE_W-1:0] ST_THR_J   = 4'd4;
   localparam logic [STATE_W-1:0] ST_THR_S   = 4'd5;
   localparam logic [STATE_W-1:0] ST_DIV_Q   = 4'd6;
   localparam logic [STATE_W-1:0] ST_DIV_R   = 4'd7;
   localparam logic [STATE_W-1:0] ST_MIX     = 4'd8;
   localparam logic [STATE_W-1:0] ST_DIV_P   = 4'd9;
   localparam logic [STATE_W-1:0] ST_EMIT    = 4'd10;

   // hash steps, in execution order
   localparam int HSTEP_W = 4;
   localparam logic [HSTEP_W-1:0] H_M0  = 4'd0;
   localparam logic [HSTEP_W-1:0] H_M1  = 4'd1;
   localparam logic [HSTEP_W-1:0] H_M2  = 4'd2;
   localparam logic [HSTEP_W-1:0] H_M3  = 4'd3;
   localparam logic [HSTEP_W-1:0] H_SK1 = 4'd4;
   localparam logic [HSTEP_W-1:0] H_SK2 = 4'd5;
   localparam logic [HSTEP_W-1:0] H_PK  = 4'd6;
   localparam logic [HSTEP_W-1:0] H_E1  = 4'd7;
   localparam logic [HSTEP_W-1:0] H_E2  = 4'd8;
   localparam logic [HSTEP_W-1:0] H_G1  = 4'd9;
   localparam logic [HSTEP_W-1:0] H_G2  = 4'd10;

   localparam logic [15:0] SKIP_STEP = 16'd6554;   // 65536 - SKIP_OFFSET

   // configuration
   logic [4:0]  column_count_ff;
   logic [5:0]  row_count_ff;
   logic [8:0]  loop_quarter_beats_ff;
   logic [15:0] jitter_fraction_ff;
   logic [15:0] skip_probability_ff;
   logic [15:0] hash_seed_ff;

   // sequencer and phase tracking
   logic [STATE_W-1:0] state_ff, state_in;
   logic [HSTEP_W-1:0] hstep_ff, hstep_in;
   logic [1:0]         mphase_ff, mphase_in;
   logic               seeded_ff, seeded_in;
   logic [15:0]        prev_phase_ff, prev_phase_in;
   logic [31:0]        bar_count_ff, bar_count_in;

   // datapath
   logic [37:0]        acc_ff, acc_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [THR_W-1:0]   thr_j_ff, thr_j_in;
   logic [THR_W-1:0]   thr_s_ff, thr_s_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [DVD_W-1:0]   n_ff, n_in;
   logic [WORD_W-1:0]  cycle_ff, cycle_in;
   logic [5:0]         nmod_ff, nmod_in;
   logic [WORD_W-1:0]  m0_ff, m0_in;
   logic [WORD_W-1:0]  m1_ff, m1_in;
   logic [WORD_W-1:0]  m2_ff, m2_in;
   logic [WORD_W-1:0]  m3_ff, m3_in;
   logic [WORD_W-1:0]  tmp_ff, tmp_in;
   logic               skip_fire_ff, skip_fire_in;
   logic [4:0]         pick_ff, pick_in;
   logic [WORD_W-1:0]  eager_ff, eager_in;
   logic [WORD_W-1:0]  gate_ff, gate_in;
   logic [4:0]         column_ff, column_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]   rsp_row_ff, rsp_row_in;
   logic               rsp_last_ff, rsp_last_in;

   // shared units
   mul_req_type        mul_req;
   logic [PROD_W-1:0]  mul_product;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // derived values
   logic [4:0]         cols;
   logic [5:0]         rows;
   logic [8:0]         q;
   logic [15:0]        jit;
   logic [WORD_W-1:0]  un;
   logic [WORD_W-1:0]  mix_src;
   logic [WORD_W-1:0]  mix_out;
   logic               gate_fire;
   logic               skip_here;
   logic               early_j;
   logic               early_s;
   logic               early;
   logic               last_col;
   logic [5:0]         lit;
   logic [DVD_W-1:0]   n_next;

   bls_mult u_mult (
      .clock      (clock),
      .req        (mul_req),
      .product_ff (mul_product)
   );

   bls_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // register clamps
   always_comb begin
      cols = column_count_ff;
      if (column_count_ff == 5'd0) begin
         cols = 5'd1;
      end else if (int'(column_count_ff) > MAX_COLUMNS) begin
         cols = 5'(MAX_COLUMNS);
      end
      rows = row_count_ff;
      if (row_count_ff < 6'd2) begin
         rows = 6'd2;
      end else if (int'(row_count_ff) > MAX_ROWS) begin
         rows = 6'(MAX_ROWS);
      end
      q = loop_quarter_beats_ff;
      if (loop_quarter_beats_ff == 9'd0) begin
         q = 9'd1;
      end else if (loop_quarter_beats_ff > 9'd256) begin
         q = 9'd256;
      end
      jit = (jitter_fraction_ff > JITTER_MAX) ? JITTER_MAX : jitter_fraction_ff;
   end

   assign un      = n_ff[WORD_W-1:0];
   assign mix_out = mix_tail(mul_product[WORD_W-1:0]);
   assign n_next  = div_rsp.quotient + DVD_W'(1);

   // first input word of each hash step
   always_comb begin
      unique case (hstep_ff) inside
         H_M0:       mix_src = {16'd0, hash_seed_ff};
         H_M1:       mix_src = {16'd0, hash_seed_ff} ^ GOLDEN;
         H_M2:       mix_src = {16'd0, hash_seed_ff} ^ GOLDEN2;
         H_M3:       mix_src = {16'd0, hash_seed_ff} + 32'd3;
         H_SK1:      mix_src = m2_ff + un;
         H_SK2:      mix_src = tmp_ff;
         H_PK:       mix_src = un ^ m3_ff;
         H_E1:       mix_src = m0_ff + {27'd0, column_ff};
         H_E2:       mix_src = tmp_ff + cycle_ff;
         H_G1:       mix_src = m1_ff + {27'd0, column_ff};
         H_G2:       mix_src = tmp_ff + un;
         default:    mix_src = '0;
      endcase
   end

   // early step decision for the current column
   always_comb begin
      gate_fire = (gate_ff < eager_ff);
      // skip applies unless the jitter gate fires with an offset of at least SKIP_OFFSET
      skip_here = skip_fire_ff && (pick_ff == column_ff) &&
                  !(gate_fire && (jit >= SKIP_OFFSET));
      early_j   = (thr_j_ff <= {1'b0, rem_ff});
      early_s   = (thr_s_ff <= {1'b0, rem_ff});
      if (skip_here) begin
         early = early_s;
      end else begin
         early = gate_fire && (jit != 16'd0) && early_j;
      end
      if (early) begin
         lit = nmod_ff;
      end else if (nmod_ff == 6'd0) begin
         lit = rows - 6'd1;
      end else begin
         lit = nmod_ff - 6'd1;
      end
      last_col = (({1'b0, column_ff} + 6'd1) == {1'b0, cols});
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      hstep_in      = hstep_ff;
      mphase_in     = mphase_ff;
      seeded_in     = seeded_ff;
      prev_phase_in = prev_phase_ff;
      bar_count_in  = bar_count_ff;
      acc_in        = acc_ff;
      num_in        = num_ff;
      thr_j_in      = thr_j_ff;
      thr_s_in      = thr_s_ff;
      rem_in        = rem_ff;
      n_in          = n_ff;
      cycle_in      = cycle_ff;
      nmod_in       = nmod_ff;
      m0_in         = m0_ff;
      m1_in         = m1_ff;
      m2_in         = m2_ff;
      m3_in         = m3_ff;
      tmp_in        = tmp_ff;
      skip_fire_in  = skip_fire_ff;
      pick_in       = pick_ff;
      eager_in      = eager_ff;
      gate_in       = gate_ff;
      column_in     = column_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_last_in   = rsp_last_ff;
      mul_req       = '{mode: MUL_PLAIN, a: '0, b: '0};
      div_req       = '{start: 1'b0, dividend: '0, divisor: '0};

      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               seeded_in     = 1'b1;
               // a drop of more than half a bar is a wrap
               if (seeded_ff && (prev_phase_ff > req_port.bar_phase) &&
                   ((prev_phase_ff - req_port.bar_phase) > HALF_BAR)) begin
                  bar_count_in = bar_count_ff + 32'd1;
               end
               prev_phase_in = req_port.bar_phase;
               state_in      = ST_NUM_HI;
            end
         end
         ST_NUM_HI: begin
            mul_req.a = bar_count_ff;
            mul_req.b = WORD_W'(rows);
            state_in  = ST_NUM_LO;
         end
         ST_NUM_LO: begin
            acc_in    = mul_product[37:0];
            mul_req.a = WORD_W'(prev_phase_ff);
            mul_req.b = WORD_W'(rows);
            state_in  = ST_NUM_SUM;
         end
         ST_NUM_SUM: begin
            // num = ({bar_count, phase} * rows) << 4
            num_in    = (NUM_W'(acc_ff) << 20) + NUM_W'({mul_product[21:0], 4'b0000});
            mul_req.a = WORD_W'(ONE_Q16 - {1'b0, jit});
            mul_req.b = WORD_W'(q);
            state_in  = ST_THR_J;
         end
         ST_THR_J: begin
            thr_j_in         = mul_product[THR_W-1:0];
            mul_req.a        = WORD_W'(SKIP_STEP);
            mul_req.b        = WORD_W'(q);
            // dividing by q << 16 is dividing num >> 16 by q
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'(num_ff[NUM_W-1:16]);
            div_req.divisor  = DVS_W'(q);
            state_in         = ST_THR_S;
         end
         ST_THR_S: begin
            thr_s_in = mul_product[THR_W-1:0];
            state_in = ST_DIV_Q;
         end
         ST_DIV_Q: begin
            if (div_rsp.done) begin
               n_in             = n_next;
               rem_in           = {div_rsp.remainder, num_ff[15:0]};
               div_req.start    = 1'b1;
               div_req.dividend = n_next;
               div_req.divisor  = DVS_W'(rows);
               state_in         = ST_DIV_R;
            end
         end
         ST_DIV_R: begin
            if (div_rsp.done) begin
               cycle_in  = div_rsp.quotient[WORD_W-1:0];
               nmod_in   = div_rsp.remainder[5:0];
               hstep_in  = H_M0;
               mphase_in = 2'd0;
               state_in  = ST_MIX;
            end
         end
         ST_MIX: begin
            mphase_in = mphase_ff + 2'd1;
            unique case (mphase_ff)
               2'd0: begin
                  mul_req.mode = MUL_MIX17;
                  mul_req.a    = mix_src;
               end
               2'd1: begin
                  mul_req.mode = MUL_MIX11;
                  mul_req.a    = mul_product[WORD_W-1:0];
               end
               2'd2: begin
                  mul_req.mode = MUL_MIX15;
                  mul_req.a    = mul_product[WORD_W-1:0];
               end
               2'd3: begin
                  hstep_in = hstep_ff + 4'd1;
                  unique case (hstep_ff) inside
                     H_M0: m0_in = mix_out;
                     H_M1: m1_in = mix_out;
                     H_M2: m2_in = mix_out;
                     H_M3: m3_in = mix_out;
                     H_SK1, H_E1, H_G1: tmp_in = mix_out;
                     H_SK2: begin
                        skip_fire_in = (skip_probability_ff != 16'd0) &&
                                       (mix_out < {skip_probability_ff, 16'd0});
                     end
                     H_PK: begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DVD_W'(mix_out);
                        div_req.divisor  = DVS_W'(cols);
                        state_in         = ST_DIV_P;
                     end
                     H_E2: eager_in = mix_out;
                     H_G2: begin
                        gate_in  = mix_out;
                        state_in = ST_EMIT;
                     end
                     default: state_in = ST_IDLE;
                  endcase
               end
            endcase
         end
         ST_DIV_P: begin
            if (div_rsp.done) begin
               pick_in   = div_rsp.remainder[4:0];
               column_in = 5'd0;
               hstep_in  = H_E1;
               mphase_in = 2'd0;
               state_in  = ST_MIX;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = column_ff[COL_W-1:0];
               rsp_row_in   = lit[ROW_W-1:0];
               rsp_last_in  = last_col;
               if (last_col) begin
                  state_in = ST_IDLE;
               end else begin
                  column_in = column_ff + 5'd1;
                  hstep_in  = H_E1;
                  mphase_in = 2'd0;
                  state_in  = ST_MIX;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hstep_ff      <= H_M0;
         mphase_ff     <= 2'd0;
         seeded_ff     <= 1'b0;
         prev_phase_ff <= '0;
         bar_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hstep_ff      <= hstep_in;
         mphase_ff     <= mphase_in;
         seeded_ff     <= seeded_in;
         prev_phase_ff <= prev_phase_in;
         bar_count_ff  <= bar_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      num_ff       <= num_in;
      thr_j_ff     <= thr_j_in;
      thr_s_ff     <= thr_s_in;
      rem_ff       <= rem_in;
      n_ff         <= n_in;
      cycle_ff     <= cycle_in;
      nmod_ff      <= nmod_in;
      m0_ff        <= m0_in;
      m1_ff        <= m1_in;
      m2_ff        <= m2_in;
      m3_ff        <= m3_in;
      tmp_ff       <= tmp_in;
      skip_fire_ff <= skip_fire_in;
      pick_ff      <= pick_in;
      eager_ff     <= eager_in;
      gate_ff      <= gate_in;
      column_ff    <= column_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // configuration writes, masked to register width
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff       <= 5'd4;
         row_count_ff          <= 6'd10;
         loop_quarter_beats_ff <= 9'd32;
         jitter_fraction_ff    <= 16'd22938;
         skip_probability_ff   <= 16'd9830;
         hash_seed_ff          <= 16'd0;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            REG_COLUMN_COUNT:       column_count_ff       <= csr_port.data[4:0];
            REG_ROW_COUNT:          row_count_ff          <= csr_port.data[5:0];
            REG_LOOP_QUARTER_BEATS: loop_quarter_beats_ff <= csr_port.data[8:0];
            REG_JITTER_FRACTION:    jitter_fraction_ff    <= csr_port.data;
            REG_SKIP_PROBABILITY:   skip_probability_ff   <= csr_port.data;
            REG_HASH_SEED:          hash_seed_ff          <= csr_port.data;
            default: ;
         endcase
      end
   end

   assign csr_port.ready        = 1'b1;
   assign req_port.ready        = (state_ff == ST_IDLE);
   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.column_index = rsp_col_ff;
   assign rsp_port.lit_row      = rsp_row_ff;
   assign rsp_port.last_column  = rsp_last_ff;

   a_last_is_final_column: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_col_ff == COL_W'(cols - 5'd1)))
      else $error("last_column on a column other than the final one");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> !req_port.ready)
      else $error("input accepted again before the sample was processed");

   a_row_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (nmod_ff < rows))
      else $error("step row index out of range");

endmodule
